// ===== design/psf_pkg.sv =====
`default_nettype none
package psf_pkg;
  localparam int MAX_LIMIT_DEF   = 65536;
  localparam int PRIME_DEPTH_DEF = 8192;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int LIMIT_W         = 16;
  localparam int PRIME_W         = 32;
  localparam int EXP_W           = 6;
  localparam int STATUS_W        = 3;
  localparam int MAX_RESULTS     = 10;

  typedef enum logic [STATUS_W-1:0] {
    ST_FACTOR     = 3'd0,
    ST_ONE        = 3'd1,
    ST_ZERO       = 3'd2,
    ST_NO_TABLE   = 3'd3,
    ST_INCOMPLETE = 3'd4,
    ST_BUILD_DONE = 3'd5
  } status_t;

  localparam logic ACT_BUILD = 1'b0;
  localparam logic ACT_FACTOR = 1'b1;
endpackage
`default_nettype wire

// ===== design/psf_if.sv =====
`default_nettype none
interface psf_in_if #(parameter int VW = 32);
  logic          valid;
  logic          ready;
  logic          action;
  logic [VW-1:0] value;
  modport source (output valid, action, value, input ready);
  modport sink (input valid, action, value, output ready);
endinterface

interface psf_out_if;
  logic                              valid;
  logic                              ready;
  logic [psf_pkg::PRIME_W-1:0]       prime;
  logic [psf_pkg::EXP_W-1:0]         exponent;
  logic [psf_pkg::STATUS_W-1:0]      status;
  logic                              last;
  modport source (output valid, prime, exponent, status, last, input ready);
  modport sink (input valid, prime, exponent, status, last, output ready);
endinterface

interface psf_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [psf_pkg::LIMIT_W-1:0]  data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== design/psf_divider.sv =====
`default_nettype none
// restoring divider, one quotient bit per cycle
module psf_divider #(
  parameter int VW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [VW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic               done,
  output logic [VW-1:0]      quotient,
  output logic [VW-1:0]      remainder
);
  localparam int CW = $clog2(VW + 1);
  logic [CW-1:0] count;
  logic          busy;
  logic [VW-1:0] dvs;
  logic [VW:0]   trial;

  assign trial = {remainder, quotient[VW-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= CW'(VW);
        quotient <= dividend;
        remainder <= '0;
        dvs <= divisor;
      end else if (busy) begin
        if (trial[VW]) begin
          remainder <= {remainder[VW-2:0], quotient[VW-1]};
          quotient <= {quotient[VW-2:0], 1'b0};
        end else begin
          remainder <= trial[VW-1:0];
          quotient <= {quotient[VW-2:0], 1'b1};
        end
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== design/prime_sieve_factorizer.sv =====
`default_nettype none
// channel   direction  word
// in        sink       action, value
// out       source     prime, exponent, status, last
// cfg       sink       data (sieve_limit)
//
// build: a fill sweep that writes every entry, a scan that reads and checks
//   each base up to sqrt(limit) and clears its multiples one by one, and a pack
//   sweep that reads and checks each entry; the single-port sieve flag memory serializes them
// factorize: trial divisions run on the single serial divider, one division
//   per listed prime tried plus one per factor found, and each listed prime
//   is fetched and checked through S_FAC_RD, S_FAC_WAIT and S_FAC_CHK
// one item at a time; the output register holds a word while out.ready is low
// reset clears the control state only, the memories are never cleared
module prime_sieve_factorizer #(
  parameter int MAX_LIMIT   = psf_pkg::MAX_LIMIT_DEF,
  parameter int PRIME_DEPTH = psf_pkg::PRIME_DEPTH_DEF,
  parameter int VALUE_WIDTH = psf_pkg::VALUE_WIDTH_DEF
) (
  input wire logic clk,
  input wire logic rst,
  psf_in_if.sink   in,
  psf_out_if.source out,
  psf_cfg_if.sink  cfg
);
  localparam int AW  = $clog2(MAX_LIMIT);
  localparam int PW  = $clog2(PRIME_DEPTH);
  localparam int CNW = $clog2(PRIME_DEPTH + 1);
  localparam int NW  = AW + 1;   // sieve index, can exceed the limit
  localparam int VW  = VALUE_WIDTH;
  localparam int RCW = $clog2(psf_pkg::MAX_RESULTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_FILL, S_SCAN_RD, S_SCAN_CHK, S_MARK, S_PACK_RD, S_PACK_CHK,
    S_FAC_RD, S_FAC_WAIT, S_FAC_CHK, S_DIV_WAIT, S_EMIT, S_TAIL
  } state_t;

  state_t state;

  // memories
  logic            sieve_mem [MAX_LIMIT];
  logic [AW-1:0]   prime_mem [PRIME_DEPTH];
  logic            sieve_rd;
  logic [AW-1:0]   prime_rd;

  // control registers
  logic [psf_pkg::LIMIT_W-1:0] sieve_limit;
  logic [AW-1:0]  lim;            // clamped limit of current build
  logic [NW-1:0]  i;              // sieve base
  logic [NW-1:0]  j;              // multiple walker
  logic [CNW-1:0] prime_count;
  logic           table_ready;
  logic [CNW-1:0] idx;
  logic [VW-1:0]  rem;
  logic [VW-1:0]  p;
  logic [psf_pkg::EXP_W-1:0] cnt;
  logic [RCW-1:0] nres;
  logic           out_valid;
  logic [psf_pkg::PRIME_W-1:0] out_prime;
  logic [psf_pkg::EXP_W-1:0]   out_exp;
  logic [psf_pkg::STATUS_W-1:0] out_status;
  logic           out_last;

  // divider
  logic           div_start;
  logic           div_done;
  logic [VW-1:0]  div_q;
  logic [VW-1:0]  div_r;

  psf_divider #(.VW(VW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(rem), .divisor(p),
    .done(div_done), .quotient(div_q), .remainder(div_r)
  );

  logic [2*VW-1:0] p_sq;
  logic [NW-1:0]   lim_ext;
  logic [2*NW-1:0] i_sq;
  assign p_sq    = p * p;
  assign lim_ext = NW'(lim);
  assign i_sq    = i * i;

  assign in.ready  = (state == S_IDLE) && !out_valid;
  assign cfg.ready = 1'b1;
  assign out.valid    = out_valid;
  assign out.prime    = out_prime;
  assign out.exponent = out_exp;
  assign out.status   = out_status;
  assign out.last     = out_last;

  // memory ports: the sieve memory reads and writes one address, the prime memory has separate read and write addresses
  logic          sv_we;
  logic [AW-1:0] sv_addr;
  logic          sv_wd;
  always_comb begin
    sv_we = 1'b0;
    sv_wd = 1'b0;
    sv_addr = i[AW-1:0];
    case (state)
      S_FILL: begin
        sv_we = 1'b1;
        sv_wd = (i >= NW'(2));
      end
      S_MARK: begin
        sv_we = 1'b1;
        sv_addr = j[AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (sv_we) sieve_mem[sv_addr] <= sv_wd;
    sieve_rd <= sieve_mem[sv_addr];
  end

  logic          pm_we;
  always_comb pm_we = (state == S_PACK_CHK) && sieve_rd &&
                      (prime_count < CNW'(PRIME_DEPTH));
  always_ff @(posedge clk) begin
    if (pm_we) prime_mem[prime_count[PW-1:0]] <= i[AW-1:0];
    prime_rd <= prime_mem[idx[PW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sieve_limit <= '0;
      prime_count <= '0;
      table_ready <= 1'b0;
      out_valid <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (cfg.valid) sieve_limit <= cfg.data;
      if (out_valid && out.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in.valid && in.ready) begin
            if (in.action == psf_pkg::ACT_BUILD) begin
              // clamp to memory size
              if (32'(sieve_limit) > 32'(MAX_LIMIT - 1)) lim <= AW'(MAX_LIMIT - 1);
              else lim <= AW'(sieve_limit);
              i <= '0;
              state <= S_FILL;
            end else if (!table_ready) begin
              out_prime <= '0; out_exp <= '0; out_last <= 1'b1;
              out_status <= psf_pkg::ST_NO_TABLE;
              out_valid <= 1'b1;
            end else if (in.value == '0) begin
              out_prime <= '0; out_exp <= '0; out_last <= 1'b1;
              out_status <= psf_pkg::ST_ZERO;
              out_valid <= 1'b1;
            end else if (in.value == VW'(1)) begin
              out_prime <= '0; out_exp <= '0; out_last <= 1'b1;
              out_status <= psf_pkg::ST_ONE;
              out_valid <= 1'b1;
            end else begin
              rem <= in.value;
              idx <= '0;
              nres <= '0;
              state <= S_FAC_RD;
            end
          end
        end
        // write 1 for 2..lim, 0 for 0 and 1
        S_FILL: begin
          if (i == lim_ext) begin
            i <= NW'(2);
            state <= S_SCAN_RD;
          end else i <= i + 1'b1;
        end
        S_SCAN_RD: begin
          if (i_sq > (2*NW)'(lim_ext)) begin
            i <= NW'(2);
            prime_count <= '0;
            state <= S_PACK_RD;
          end else state <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (sieve_rd && (i + i) <= lim_ext) begin
            j <= i + i;
            state <= S_MARK;
          end else begin
            i <= i + 1'b1;
            state <= S_SCAN_RD;
          end
        end
        S_MARK: begin
          if (j + i > lim_ext) begin
            i <= i + 1'b1;
            state <= S_SCAN_RD;
          end else j <= j + i;
        end
        S_PACK_RD: begin
          if (i > lim_ext) begin
            table_ready <= 1'b1;
            out_prime <= psf_pkg::PRIME_W'(prime_count);
            out_exp <= '0; out_last <= 1'b1;
            out_status <= psf_pkg::ST_BUILD_DONE;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end else state <= S_PACK_CHK;
        end
        S_PACK_CHK: begin
          if (pm_we) prime_count <= prime_count + 1'b1;
          i <= i + 1'b1;
          state <= S_PACK_RD;
        end
        // factorization
        S_FAC_RD: begin
          if (out_valid) state <= S_FAC_RD;
          else if (rem == VW'(1)) begin
            // last word already sent; nothing pending
            state <= S_IDLE;
          end else if (idx >= prime_count ||
                       nres >= RCW'(psf_pkg::MAX_RESULTS - 1)) begin
            state <= S_TAIL;
          end else state <= S_FAC_WAIT;
        end
        S_FAC_WAIT: begin
          p <= VW'(prime_rd);
          state <= S_FAC_CHK;
        end
        S_FAC_CHK: begin
          if (p_sq > (2*VW)'(rem)) begin
            out_prime <= psf_pkg::PRIME_W'(rem);
            out_exp <= psf_pkg::EXP_W'(1);
            out_status <= psf_pkg::ST_FACTOR;
            out_last <= 1'b1;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            cnt <= '0;
            div_start <= 1'b1;
            state <= S_DIV_WAIT;
          end
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            if (div_r == '0) begin
              rem <= div_q;
              cnt <= cnt + 1'b1;
              div_start <= 1'b1;
            end else if (cnt != '0) state <= S_EMIT;
            else begin
              idx <= idx + 1'b1;
              state <= S_FAC_RD;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid) begin
            // this word is last when the cofactor is fully consumed
            out_prime <= psf_pkg::PRIME_W'(p);
            out_exp <= cnt;
            out_status <= psf_pkg::ST_FACTOR;
            out_last <= (rem == VW'(1));
            out_valid <= 1'b1;
            nres <= nres + 1'b1;
            idx <= idx + 1'b1;
            state <= (rem == VW'(1)) ? S_IDLE : S_FAC_RD;
          end
        end
        S_TAIL: begin
          if (!out_valid) begin
            out_prime <= psf_pkg::PRIME_W'(rem);
            out_exp <= '0;
            out_status <= psf_pkg::ST_INCOMPLETE;
            out_last <= 1'b1;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sim/psf_checker.sv =====
module psf_checker (
  input  logic clk,
  input  logic rst,
  psf_in_if    in_ch,
  psf_out_if   out_ch,
  psf_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [psf_pkg::PRIME_W-1:0] prime;
    logic [psf_pkg::EXP_W-1:0]   exponent;
    psf_pkg::status_t            status;
    logic                        last;
  } factor_word_t;

  factor_word_t want_q[$];
  bit           sieve[psf_pkg::MAX_LIMIT_DEF];
  int unsigned  plist[psf_pkg::PRIME_DEPTH_DEF];
  int unsigned  pcount;
  bit           built;
  logic [psf_pkg::LIMIT_W-1:0] limit_reg;
  int           fails;

  function automatic void rebuild_table();
    int unsigned lim;
    int unsigned i;
    int unsigned j;
    lim = limit_reg;
    if (lim > psf_pkg::MAX_LIMIT_DEF - 1) lim = psf_pkg::MAX_LIMIT_DEF - 1;
    for (i = 0; i <= lim; i++) sieve[i] = 1'b1;
    sieve[0] = 1'b0;
    if (lim >= 1) sieve[1] = 1'b0;
    for (i = 2; longint'(i) * i <= lim; i++) begin
      if (sieve[i]) begin
        for (j = 2 * i; j <= lim; j += i) sieve[j] = 1'b0;
      end
    end
    pcount = 0;
    for (i = 2; i <= lim; i++) begin
      if (sieve[i] && pcount < psf_pkg::PRIME_DEPTH_DEF) begin
        plist[pcount] = i;
        pcount++;
      end
    end
    built = 1'b1;
  endfunction

  function automatic factor_word_t mk(longint unsigned p, int e, psf_pkg::status_t s);
    factor_word_t w;
    w.prime = p[psf_pkg::PRIME_W-1:0];
    w.exponent = e[psf_pkg::EXP_W-1:0];
    w.status = s;
    w.last = 1'b0;
    return w;
  endfunction

  function automatic void predict_factors(logic act, logic [31:0] v);
    factor_word_t words[$];
    longint unsigned rem;
    longint unsigned p;
    int cnt;
    int unsigned idx;
    rem = v;
    if (act == psf_pkg::ACT_BUILD) begin
      rebuild_table();
      words = {words, mk(pcount, 0, psf_pkg::ST_BUILD_DONE)};
    end else if (!built) begin
      words = {words, mk(0, 0, psf_pkg::ST_NO_TABLE)};
    end else if (rem == 0) begin
      words = {words, mk(0, 0, psf_pkg::ST_ZERO)};
    end else if (rem == 1) begin
      words = {words, mk(0, 0, psf_pkg::ST_ONE)};
    end else begin
      for (idx = 0; idx < pcount && rem != 1; idx++) begin
        if (words.size() >= psf_pkg::MAX_RESULTS - 1) break;
        p = plist[idx];
        if (p * p > rem) begin
          words = {words, mk(rem, 1, psf_pkg::ST_FACTOR)};
          rem = 1;
          break;
        end
        cnt = 0;
        while (rem % p == 0) begin
          rem = rem / p;
          cnt++;
        end
        if (cnt != 0) words = {words, mk(p, cnt, psf_pkg::ST_FACTOR)};
      end
      if (rem != 1) words = {words, mk(rem, 0, psf_pkg::ST_INCOMPLETE)};
    end
    words[words.size()-1].last = 1'b1;
    want_q = {want_q, words};
  endfunction

  always @(posedge clk) begin
    factor_word_t w;
    if (rst) begin
      want_q.delete();
      built = 1'b0;
      pcount = 0;
      limit_reg = '0;
      fails = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) limit_reg = cfg_ch.data;
      if (out_ch.valid && out_ch.ready) begin
        if (want_q.size() == 0) begin
          fails++;
          $display("%0t unexpected word: prime %0d exp %0d status %0d last %0d", $time,
                   out_ch.prime, out_ch.exponent, out_ch.status, out_ch.last);
        end else begin
          w = want_q.pop_front();
          if (out_ch.prime !== w.prime || out_ch.exponent !== w.exponent ||
              out_ch.status !== w.status || out_ch.last !== w.last) begin
            fails++;
            $display("%0t mismatch: expected prime %0d exp %0d status %0d last %0d, %s",
                     $time, w.prime, w.exponent, w.status, w.last, "actual below");
            $display("%0t   actual prime %0d exp %0d status %0d last %0d", $time,
                     out_ch.prime, out_ch.exponent, out_ch.status, out_ch.last);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) predict_factors(in_ch.action, in_ch.value);
    end
    fail_count <= fails;
    pending <= want_q.size();
  end
endmodule

// ===== sim/prime_sieve_factorizer_test.sv =====
module prime_sieve_factorizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 1500000;
  localparam int LW = psf_pkg::LIMIT_W;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  bit   calm_tx = 1'b0;

  psf_in_if #(.VW(psf_pkg::VALUE_WIDTH_DEF)) in_ch ();
  psf_out_if out_ch ();
  psf_cfg_if cfg_ch ();

  prime_sieve_factorizer uut (
    .clk (clk),
    .rst (rst),
    .in  (in_ch),
    .out (out_ch),
    .cfg (cfg_ch)
  );

  psf_checker chk (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // watchdog: only cycles with no handshake anywhere count
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // result side: random stalls, one long hold-off, a stall-free stretch
  int out_words = 0;
  int hold_left = 0;
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        out_words++;
        // long hold so the block backs up and stalls its input
        if (out_words == 40) hold_left = 500;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (out_words >= 70 && out_words < 120) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= 17);
      end
    end
  end

  // offer one word, leave valid high afterward so back-to-back words need no drop
  task automatic send_item(logic act, logic [31:0] v);
    if (!calm_tx && $urandom_range(0, 99) < 17) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= act;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // wait until every predicted word has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_limit(logic [psf_pkg::LIMIT_W-1:0] lim);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= lim;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // half of the values are smooth numbers so factor runs go deep, plus raw noise and edges
  function automatic logic [31:0] pick_value();
    int unsigned small_primes[15] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47};
    longint unsigned acc;
    longint unsigned f;
    acc = 1;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        repeat ($urandom_range(1, 8)) begin
          f = small_primes[$urandom_range(0, 14)];
          if (acc * f <= 64'hFFFF_FFFF) acc = acc * f;
        end
        return acc[31:0];
      end
      5, 6: return $urandom;
      7: return $urandom_range(0, 20);
      8: return $urandom_range(2, 400) * $urandom_range(1, 1000);
      default: return ~($urandom_range(0, 3) << $urandom_range(0, 31));
    endcase
  endfunction

  initial begin
    int lims[4];
    int item_no;
    in_ch.valid = 1'b0;
    in_ch.action = psf_pkg::ACT_BUILD;
    in_ch.value = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // requests before any table exists
    send_item(psf_pkg::ACT_FACTOR, 32'd12);
    send_item(psf_pkg::ACT_FACTOR, 32'd0);
    // empty table: limit zero, then limit one
    write_limit(16'd0);
    send_item(psf_pkg::ACT_BUILD, 32'hFFFF_FFFF);
    send_item(psf_pkg::ACT_FACTOR, 32'd12);
    send_item(psf_pkg::ACT_FACTOR, 32'd1);
    send_item(psf_pkg::ACT_FACTOR, 32'd0);
    write_limit(16'd1);
    send_item(psf_pkg::ACT_BUILD, 32'd0);
    send_item(psf_pkg::ACT_FACTOR, 32'd7);
    // table holding only two
    write_limit(16'd2);
    send_item(psf_pkg::ACT_BUILD, 32'd0);
    send_item(psf_pkg::ACT_FACTOR, 32'h8000_0000);
    send_item(psf_pkg::ACT_FACTOR, 32'hFFFF_FFFF);
    write_limit(16'd100);
    send_item(psf_pkg::ACT_BUILD, 32'd0);
    send_item(psf_pkg::ACT_FACTOR, 32'hFFFF_FFFF);
    send_item(psf_pkg::ACT_FACTOR, 32'd9409);
    send_item(psf_pkg::ACT_FACTOR, 32'd614889782);
    send_item(psf_pkg::ACT_FACTOR, 32'd2147483647);
    // new limit without a rebuild: old table stays in use
    write_limit(16'hFFFF);
    send_item(psf_pkg::ACT_FACTOR, 32'd360);
    send_item(psf_pkg::ACT_BUILD, 32'd0);
    send_item(psf_pkg::ACT_FACTOR, 32'hFFFF_FFFF);
    send_item(psf_pkg::ACT_FACTOR, 32'd4294836225);

    // random phases with small tables to keep factor runs short
    lims = '{3, 47, 300, $urandom_range(2, 400)};
    item_no = 0;
    foreach (lims[ph]) begin
      write_limit(LW'(lims[ph]));
      send_item(psf_pkg::ACT_BUILD, $urandom);
      repeat (30) begin
        calm_tx = (item_no >= 60 && item_no < 95);
        if ($urandom_range(0, 9) == 0) send_item(psf_pkg::ACT_BUILD, $urandom);
        else send_item(psf_pkg::ACT_FACTOR, pick_value());
        item_no++;
      end
    end
    calm_tx = 1'b0;

    drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
